### hdl/cartesian_to_spherical_macros.svh
// Assertion macros shared by the cartesian-to-spherical converter.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2S_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2s: same-cycle check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define C2S_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(n) (cons)) \
    else $error("c2s: delayed check failed");

`endif

### hdl/c2s_pkg.sv
// Shared constants, arctangent table and gain functions for the converter.
package c2s_pkg;

  // Default configuration of the converter.
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int ANGLE_WIDTH_DEF   = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  // Guard bits added below the coordinate LSB inside the CORDIC.
  localparam int GUARD = 20;

  // Angle accumulator: 32-bit binary angle, 2^32 is a full turn.
  localparam int ACC_W = 32;
  localparam int ATAN_DEPTH = 24;

  localparam logic [ACC_W-1:0] ANG_QUARTER_POS = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ANG_QUARTER_NEG = 32'hC000_0000;

  // atan(2^-i) in accumulator units, rounded to nearest.
  localparam logic [ACC_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // Restoring long division, used only to build constants.
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Integer square root by the digit-by-digit method.
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_w;
    n     = n_in;
    res   = '0;
    bit_w = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (bit_w > n) begin
        bit_w = bit_w >> 2;
      end
    end
    for (int j = 0; j < 32; j++) begin
      if (bit_w != 0) begin
        if (n >= res + bit_w) begin
          n   = n - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
        bit_w = bit_w >> 2;
      end
    end
    return res;
  endfunction

  // CORDIC gain correction factor in Q31 for the given number of stages.
  function automatic logic [30:0] gain_q31(input int stages);
    logic [63:0] k2;
    logic [63:0] d;
    logic [63:0] k;
    k2 = 64'd1 << 62;
    for (int i = 0; i < ATAN_DEPTH; i++) begin
      if (i < stages) begin
        d  = (64'd1 << (2 * i)) + 64'd1;
        k2 = k2 - udiv64(k2, d);
      end
    end
    k = isqrt64(k2);
    return k[30:0];
  endfunction

endpackage

### hdl/c2s_cordic_stage.sv
// One registered CORDIC vectoring iteration with a sideband word.
module c2s_cordic_stage
  import c2s_pkg::*;
#(
  parameter int DW     = COORD_WIDTH_DEF + GUARD + 3,
  parameter int SIDE_W = 1,
  parameter int STAGE  = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [DW-1:0]     in_x,
  input  logic signed [DW-1:0]     in_y,
  input  logic        [ACC_W-1:0]  in_ang,
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output logic signed [DW-1:0]     out_x,
  output logic signed [DW-1:0]     out_y,
  output logic        [ACC_W-1:0]  out_ang,
  output logic        [SIDE_W-1:0] out_side
);

  logic signed [DW-1:0]    x_sh;
  logic signed [DW-1:0]    y_sh;
  logic signed [DW-1:0]    x_next;
  logic signed [DW-1:0]    y_next;
  logic        [ACC_W-1:0] ang_next;

  // Rotate toward the x axis; the sign of y picks the direction.
  always_comb begin
    x_sh = in_x >>> STAGE;
    y_sh = in_y >>> STAGE;
    if (!in_y[DW-1]) begin
      x_next   = in_x + y_sh;
      y_next   = in_y - x_sh;
      ang_next = in_ang + ATAN_TAB[STAGE];
    end else begin
      x_next   = in_x - y_sh;
      y_next   = in_y + x_sh;
      ang_next = in_ang - ATAN_TAB[STAGE];
    end
  end

  // Valid bit is reset; the word itself is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_x    <= x_next;
    out_y    <= y_next;
    out_ang  <= ang_next;
    out_side <= in_side;
  end

endmodule

### hdl/c2s_cordic_pass.sv
// A full CORDIC vectoring pass: a chain of registered iterations.
module c2s_cordic_pass
  import c2s_pkg::*;
#(
  parameter int DW     = COORD_WIDTH_DEF + GUARD + 3,
  parameter int SIDE_W = 1,
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [DW-1:0]     in_x,
  input  logic signed [DW-1:0]     in_y,
  input  logic        [ACC_W-1:0]  in_ang,
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output logic signed [DW-1:0]     out_x,
  output logic        [ACC_W-1:0]  out_ang,
  output logic        [SIDE_W-1:0] out_side
);

  logic                     v_chain    [STAGES+1];
  logic signed [DW-1:0]     x_chain    [STAGES+1];
  logic signed [DW-1:0]     y_chain    [STAGES+1];
  logic        [ACC_W-1:0]  ang_chain  [STAGES+1];
  logic        [SIDE_W-1:0] side_chain [STAGES+1];

  assign v_chain[0]    = in_valid;
  assign x_chain[0]    = in_x;
  assign y_chain[0]    = in_y;
  assign ang_chain[0]  = in_ang;
  assign side_chain[0] = in_side;

  // One stage per iteration, each with its own shift and table entry.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    c2s_cordic_stage #(
      .DW     (DW),
      .SIDE_W (SIDE_W),
      .STAGE  (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (v_chain[i]),
      .in_x      (x_chain[i]),
      .in_y      (y_chain[i]),
      .in_ang    (ang_chain[i]),
      .in_side   (side_chain[i]),
      .out_valid (v_chain[i+1]),
      .out_x     (x_chain[i+1]),
      .out_y     (y_chain[i+1]),
      .out_ang   (ang_chain[i+1]),
      .out_side  (side_chain[i+1])
    );
  end

  // The residual y of the last stage is not needed downstream.
  assign out_valid = v_chain[STAGES];
  assign out_x     = x_chain[STAGES];
  assign out_ang   = ang_chain[STAGES];
  assign out_side  = side_chain[STAGES];

endmodule

### hdl/c2s_gain_mul.sv
// Two-stage multiply of a CORDIC magnitude by the Q31 gain, rounded half up.
module c2s_gain_mul
  import c2s_pkg::*;
#(
  parameter int DW     = COORD_WIDTH_DEF + GUARD + 3,
  parameter int SIDE_W = 1,
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic signed [DW-1:0]     in_mag,
  input  logic        [SIDE_W-1:0] in_side,
  output logic                     out_valid,
  output logic signed [DW-1:0]     out_mag,
  output logic        [SIDE_W-1:0] out_side
);

  localparam logic [30:0] K_Q31 = gain_q31(STAGES);
  // Magnitude is never negative, so its sign bit is dropped.
  localparam int AEW = (DW - 1 > 32) ? DW - 1 : 32;
  localparam int HW  = AEW - 31;
  localparam logic [62:0] LO_HALF = 63'd1 << 30;

  logic [AEW-1:0]    a_ext;
  logic              v_a;
  logic [61:0]       p_lo;
  logic [HW+30:0]    p_hi;
  logic [SIDE_W-1:0] side_a;
  logic [62:0]       lo_rnd;
  logic [HW+31:0]    sum_next;

  assign a_ext = AEW'(in_mag[DW-2:0]);

  // Stage A: low and high partial products against the gain.
  always_ff @(posedge clk) begin
    p_lo   <= 62'(a_ext[30:0]) * 62'(K_Q31);
    p_hi   <= (HW+31)'(a_ext[AEW-1:31]) * (HW+31)'(K_Q31);
    side_a <= in_side;
  end

  // Stage B: round the low product and add it to the high product.
  always_comb begin
    lo_rnd   = {1'b0, p_lo} + LO_HALF;
    sum_next = (HW+32)'(p_hi) + (HW+32)'(lo_rnd[62:31]);
  end

  always_ff @(posedge clk) begin
    out_mag  <= DW'(sum_next);
    out_side <= side_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v_a       <= in_valid;
      out_valid <= v_a;
    end
  end

endmodule

### hdl/cartesian_to_spherical.sv
// Top level: pipelined cartesian-to-spherical conversion with two CORDIC passes.
//
//  channel  | handshake          | words
//  ---------+--------------------+------------------------------------
//  input    | start / busy       | x_coord, y_coord, z_coord
//  result   | done (one cycle)   | azimuth, elevation, range_len
//
// A new point is taken in every cycle outside reset; each result passes through
// the input register, the first chain of CORDIC iterations and its gain
// multiplier, the second chain and its gain multiplier, and the output register.
// Reset is synchronous and clears every valid bit; busy is high only during reset.
// The result strobe cannot be held off, so the pipeline never stalls.
`include "cartesian_to_spherical_macros.svh"

module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic                          done,
  output logic signed [ANGLE_WIDTH-1:0] azimuth,
  output logic signed [ANGLE_WIDTH-1:0] elevation,
  output logic        [COORD_WIDTH-1:0] range_len
);

  localparam int DW       = COORD_WIDTH + GUARD + 3;
  localparam int SIDE1_W  = DW + 2;
  localparam int SIDEG1_W = DW + ACC_W + 1;
  localparam int SIDE2_W  = ACC_W + 1;
  localparam int SIDEG2_W = 2 * ACC_W + 1;
  localparam int LATENCY  = 2 * CORDIC_STAGES + 6;
  localparam logic [ACC_W-1:0] ANG_HALF = ACC_W'(1) << (31 - ANGLE_WIDTH);
  localparam logic [DW:0]      RND_HALF = (DW+1)'(1) << (GUARD - 1);

  logic signed [DW-1:0]    x_ext;
  logic signed [DW-1:0]    y_ext;
  logic signed [DW-1:0]    z_ext;
  logic signed [DW-1:0]    x0_next;
  logic signed [DW-1:0]    y0_next;
  logic        [ACC_W-1:0] ang0_next;
  logic                    v0;
  logic signed [DW-1:0]    x0;
  logic signed [DW-1:0]    y0;
  logic signed [DW-1:0]    z0;
  logic        [ACC_W-1:0] ang0;
  logic                    xy_zero0;
  logic                    all_zero0;

  logic                    v1;
  logic signed [DW-1:0]    mag1;
  logic        [ACC_W-1:0] az1;
  logic        [SIDE1_W-1:0] side1;
  logic        [ACC_W-1:0] az1_fixed;

  logic                    vg1;
  logic signed [DW-1:0]    magg1;
  logic        [SIDEG1_W-1:0] sideg1;

  logic                    v2;
  logic signed [DW-1:0]    mag2;
  logic        [ACC_W-1:0] el2;
  logic        [SIDE2_W-1:0] side2;

  logic                    vg2;
  logic signed [DW-1:0]    magg2;
  logic        [SIDEG2_W-1:0] sideg2;

  logic        [DW:0]      rnd_full;
  logic        [ACC_W-1:0] az_rnd;
  logic        [ACC_W-1:0] el_rnd;
  logic                    zero_f;

  // No back-pressure: the pipeline takes a word every cycle outside reset.
  assign busy = rst;

  // Scale the coordinates by the guard bits.
  assign x_ext = {{3{x_coord[COORD_WIDTH-1]}}, x_coord, {GUARD{1'b0}}};
  assign y_ext = {{3{y_coord[COORD_WIDTH-1]}}, y_coord, {GUARD{1'b0}}};
  assign z_ext = {{3{z_coord[COORD_WIDTH-1]}}, z_coord, {GUARD{1'b0}}};

  // Fold a left-half-plane vector into the right half by a quarter turn.
  always_comb begin
    x0_next   = x_ext;
    y0_next   = y_ext;
    ang0_next = '0;
    if (x_ext[DW-1]) begin
      if (!y_ext[DW-1]) begin
        x0_next   = y_ext;
        y0_next   = -x_ext;
        ang0_next = ANG_QUARTER_POS;
      end else begin
        x0_next   = -y_ext;
        y0_next   = x_ext;
        ang0_next = ANG_QUARTER_NEG;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    x0        <= x0_next;
    y0        <= y0_next;
    z0        <= z_ext;
    ang0      <= ang0_next;
    xy_zero0  <= (x_coord == '0) && (y_coord == '0);
    all_zero0 <= (x_coord == '0) && (y_coord == '0) && (z_coord == '0);
  end

  // First pass: azimuth and horizontal length from (x, y).
  c2s_cordic_pass #(
    .DW     (DW),
    .SIDE_W (SIDE1_W),
    .STAGES (CORDIC_STAGES)
  ) u_pass_az (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .in_x      (x0),
    .in_y      (y0),
    .in_ang    (ang0),
    .in_side   ({z0, xy_zero0, all_zero0}),
    .out_valid (v1),
    .out_x     (mag1),
    .out_ang   (az1),
    .out_side  (side1)
  );

  // A point on the z axis has no defined azimuth; it reads as zero.
  assign az1_fixed = side1[1] ? '0 : az1;

  c2s_gain_mul #(
    .DW     (DW),
    .SIDE_W (SIDEG1_W),
    .STAGES (CORDIC_STAGES)
  ) u_gain_h (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v1),
    .in_mag    (mag1),
    .in_side   ({side1[SIDE1_W-1:2], az1_fixed, side1[0]}),
    .out_valid (vg1),
    .out_mag   (magg1),
    .out_side  (sideg1)
  );

  // Second pass: elevation and range from (horizontal length, z).
  c2s_cordic_pass #(
    .DW     (DW),
    .SIDE_W (SIDE2_W),
    .STAGES (CORDIC_STAGES)
  ) u_pass_el (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vg1),
    .in_x      (magg1),
    .in_y      (sideg1[SIDEG1_W-1:ACC_W+1]),
    .in_ang    ('0),
    .in_side   (sideg1[ACC_W:0]),
    .out_valid (v2),
    .out_x     (mag2),
    .out_ang   (el2),
    .out_side  (side2)
  );

  c2s_gain_mul #(
    .DW     (DW),
    .SIDE_W (SIDEG2_W),
    .STAGES (CORDIC_STAGES)
  ) u_gain_r (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_mag    (mag2),
    .in_side   ({side2[ACC_W:1], el2, side2[0]}),
    .out_valid (vg2),
    .out_mag   (magg2),
    .out_side  (sideg2)
  );

  // Round the range and both angles half up.
  always_comb begin
    rnd_full = {1'b0, magg2} + RND_HALF;
    az_rnd   = sideg2[SIDEG2_W-1:ACC_W+1] + ANG_HALF;
    el_rnd   = sideg2[ACC_W:1] + ANG_HALF;
    zero_f   = sideg2[0];
  end

  // Output register: saturate the range, clear everything for the origin.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vg2;
    end
  end

  always_ff @(posedge clk) begin
    if (zero_f) begin
      azimuth   <= '0;
      elevation <= '0;
      range_len <= '0;
    end else begin
      azimuth   <= az_rnd[ACC_W-1 -: ANGLE_WIDTH];
      elevation <= el_rnd[ACC_W-1 -: ANGLE_WIDTH];
      if (|rnd_full[DW:GUARD+COORD_WIDTH]) begin
        range_len <= '1;
      end else begin
        range_len <= rnd_full[GUARD+COORD_WIDTH-1:GUARD];
      end
    end
  end

  // Every accepted point gives a result after the fixed latency, and no other.
  `C2S_ASSERT_DELAY(a_result_follows, start && !busy, LATENCY, done)
  `C2S_ASSERT_IMP(a_result_has_cause, done, $past(start && !busy, LATENCY))
  // The origin comes out as all zeros.
  `C2S_ASSERT_DELAY(a_origin_zero,
    start && !busy && x_coord == '0 && y_coord == '0 && z_coord == '0, LATENCY,
    done && azimuth == '0 && elevation == '0 && range_len == '0)

endmodule
